// File: src/ppp_pkg.sv
// ----------------------------------------------------------------------------
// ppp_pkg: shared constants for the perspective point projection block
// Widths of the fixed-point datapath, codes and reset values.
// ----------------------------------------------------------------------------
package ppp_pkg;

    localparam int W         = 32;
    localparam int FRAC_BITS = 16;
    localparam int VP_W      = 14;

    // Product sum width, clip value width, divider widths.
    localparam int SUM_W  = 2 * W + 2;
    localparam int CLIP_W = 2 * W + 3 - FRAC_BITS;
    localparam int MAG_W  = CLIP_W + 1;
    localparam int DEN_W  = CLIP_W;
    localparam int REM_W  = DEN_W + 1;
    localparam int NUM_W  = MAG_W + VP_W + FRAC_BITS;

    // Smallest visible w: round(0.001 * 2^FRAC_BITS).
    localparam int THRESH = ((1 << FRAC_BITS) + 500) / 1000;

    localparam int IN_TDATA_W  = 136;
    localparam int OUT_TDATA_W = 96;
    localparam int CFG_IDX_W   = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;

    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_PROJECT = 1'b1;

    localparam logic [VP_W-1:0] WIDTH_RESET  = 14'd1920;
    localparam logic [VP_W-1:0] HEIGHT_RESET = 14'd1080;

    localparam logic [W-1:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [W-1:0] SAT_NEG = 32'h8000_0000;

endpackage

// File: src/perspective_point_projection.sv
// ----------------------------------------------------------------------------
// perspective_point_projection: world point to screen pixel projection
// Throughput: one request per cycle; the 32-stage quotient pipeline sets depth.
// A stall at the output holds the whole pipeline; load requests give no result.
// Reset clears all valid bits and sets the viewport to 1920 by 1080; the
// matrix is not cleared and must be loaded before the first projection.
// ----------------------------------------------------------------------------
module perspective_point_projection (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // element_index, element_value, point_x, point_y, point_z, zero pad
    input  logic [ppp_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    // operation
    input  logic                               i_s_axis_tuser,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // screen_x, screen_y, clip_depth
    output logic [ppp_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata,
    // visible
    output logic                               o_m_axis_tuser,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [ppp_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [ppp_pkg::VP_W-1:0]           i_cfg_data
);

    localparam int Q  = ppp_pkg::W;
    localparam int CW = ppp_pkg::CLIP_W;
    localparam int PW = ppp_pkg::NUM_W - ppp_pkg::FRAC_BITS;

    logic                   ce;
    logic                   acc;
    logic [ppp_pkg::VP_W-1:0] r_width;
    logic [ppp_pkg::VP_W-1:0] r_height;

    logic                   c_valid;
    logic signed [CW-1:0]   c_x;
    logic signed [CW-1:0]   c_y;
    logic signed [CW-1:0]   c_w;

    // Stage 3 and 4 registers.
    logic                   r_v3, r_v4;
    logic                   r_vis3, r_vis4;
    logic [Q-1:0]           r_w3, r_w4;
    logic [ppp_pkg::MAG_W-1:0] r_magx, r_magy;
    logic                   r_negx3, r_negy3, r_negx4, r_negy4;
    logic [ppp_pkg::DEN_W-1:0] r_den3, r_den4;
    logic [ppp_pkg::NUM_W-1:0] r_numx, r_numy;

    logic signed [CW:0]     sx, sy;
    logic                   vis;

    logic                   r_dv   [Q+1];
    logic                   r_dvis [Q+1];
    logic [Q-1:0]           r_dw   [Q+1];
    logic [Q-1:0]           resx, resy;

    logic                   r_out_valid;
    logic                   r_out_vis;
    logic [Q-1:0]           r_out_x, r_out_y, r_out_w;

    assign ce  = !r_out_valid || i_m_axis_tready;
    assign acc = i_s_axis_tvalid && ce;
    assign o_s_axis_tready = ce;
    assign o_cfg_ready     = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= ppp_pkg::WIDTH_RESET;
            r_height <= ppp_pkg::HEIGHT_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                ppp_pkg::CFG_WIDTH:  r_width  <= i_cfg_data;
                ppp_pkg::CFG_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    ppp_clip u_clip (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (ce),
        .i_load  (acc && (i_s_axis_tuser == ppp_pkg::OP_LOAD)),
        .i_proj  (acc && (i_s_axis_tuser == ppp_pkg::OP_PROJECT)),
        .i_idx   (i_s_axis_tdata[3:0]),
        .i_val   (i_s_axis_tdata[35:4]),
        .i_px    (i_s_axis_tdata[67:36]),
        .i_py    (i_s_axis_tdata[99:68]),
        .i_pz    (i_s_axis_tdata[131:100]),
        .o_valid (c_valid),
        .o_cx    (c_x),
        .o_cy    (c_y),
        .o_cw    (c_w)
    );

    assign sx  = (CW+1)'(c_w) + (CW+1)'(c_x);
    assign sy  = (CW+1)'(c_w) - (CW+1)'(c_y);
    assign vis = (c_w > 0) && (c_w >= $signed(CW'(ppp_pkg::THRESH)));

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_vis3  <= vis;
            r_negx3 <= sx[CW];
            r_negy3 <= sy[CW];
            r_magx  <= sx[CW] ? ppp_pkg::MAG_W'(-sx) : ppp_pkg::MAG_W'(sx);
            r_magy  <= sy[CW] ? ppp_pkg::MAG_W'(-sy) : ppp_pkg::MAG_W'(sy);
            r_den3  <= {c_w[CW-2:0], 1'b0};
            r_w3    <= (c_w > $signed(CW'(ppp_pkg::SAT_POS))) ? ppp_pkg::SAT_POS
                                                              : c_w[Q-1:0];
            r_vis4  <= r_vis3;
            r_negx4 <= r_negx3;
            r_negy4 <= r_negy3;
            r_den4  <= r_den3;
            r_w4    <= r_w3;
            r_numx  <= {PW'(r_magx) * r_width, {ppp_pkg::FRAC_BITS{1'b0}}};
            r_numy  <= {PW'(r_magy) * r_height, {ppp_pkg::FRAC_BITS{1'b0}}};
        end
    end

    ppp_div u_div_x (
        .i_clk (i_clk),
        .i_en  (ce),
        .i_num (r_numx),
        .i_den (r_den4),
        .i_neg (r_negx4),
        .o_res (resx)
    );

    ppp_div u_div_y (
        .i_clk (i_clk),
        .i_en  (ce),
        .i_num (r_numy),
        .i_den (r_den4),
        .i_neg (r_negy4),
        .o_res (resy)
    );

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_dvis[0] <= r_vis4;
            r_dw[0]   <= r_w4;
            for (int k = 1; k <= Q; k++) begin
                r_dvis[k] <= r_dvis[k-1];
                r_dw[k]   <= r_dw[k-1];
            end
            r_out_vis <= r_dvis[Q];
            r_out_x   <= r_dvis[Q] ? resx : '0;
            r_out_y   <= r_dvis[Q] ? resy : '0;
            r_out_w   <= r_dvis[Q] ? r_dw[Q] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3        <= 1'b0;
            r_v4        <= 1'b0;
            r_out_valid <= 1'b0;
            for (int k = 0; k <= Q; k++) begin
                r_dv[k] <= 1'b0;
            end
        end else if (ce) begin
            r_v3    <= c_valid;
            r_v4    <= r_v3;
            r_dv[0] <= r_v4;
            for (int k = 1; k <= Q; k++) begin
                r_dv[k] <= r_dv[k-1];
            end
            r_out_valid <= r_dv[Q];
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out_w, r_out_y, r_out_x};
    assign o_m_axis_tuser  = r_out_vis;

endmodule

// File: src/ppp_clip.sv
// ----------------------------------------------------------------------------
// ppp_clip: matrix store and clip-space transform
// Holds the 4x4 matrix and computes clip x, y and w in two register stages.
// ----------------------------------------------------------------------------
module ppp_clip (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_en,
    input  logic                                  i_load,
    input  logic                                  i_proj,
    input  logic [3:0]                            i_idx,
    input  logic signed [ppp_pkg::W-1:0]          i_val,
    input  logic signed [ppp_pkg::W-1:0]          i_px,
    input  logic signed [ppp_pkg::W-1:0]          i_py,
    input  logic signed [ppp_pkg::W-1:0]          i_pz,
    output logic                                  o_valid,
    output logic signed [ppp_pkg::CLIP_W-1:0]     o_cx,
    output logic signed [ppp_pkg::CLIP_W-1:0]     o_cy,
    output logic signed [ppp_pkg::CLIP_W-1:0]     o_cw
);

    logic signed [ppp_pkg::W-1:0]     r_mat [16];
    logic signed [2*ppp_pkg::W-1:0]   r_prod [3][3];
    logic signed [ppp_pkg::W-1:0]     r_off [3];
    logic                             r_v1;
    logic                             r_v2;
    logic signed [ppp_pkg::CLIP_W-1:0] r_c [3];
    logic signed [ppp_pkg::CLIP_W-1:0] n_c [3];
    logic signed [ppp_pkg::W-1:0]     pt [3];

    // Rows used: x is row 0, y is row 1, w is row 3.
    localparam int ROW [3] = '{0, 1, 3};

    assign pt[0] = i_px;
    assign pt[1] = i_py;
    assign pt[2] = i_pz;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_mat[i_idx] <= i_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_prod[r][c] <= r_mat[ROW[r]*4 + c] * pt[c];
                end
                r_off[r] <= r_mat[ROW[r]*4 + 3];
            end
            r_c <= n_c;
        end
    end

    // The sum of the three full products shifted once equals the per-term
    // floor plus the floor of the summed fractions.
    always_comb begin
        logic signed [ppp_pkg::SUM_W-1:0] sum;
        logic signed [ppp_pkg::SUM_W-1:0] sh;
        for (int r = 0; r < 3; r++) begin
            sum = ppp_pkg::SUM_W'(r_prod[r][0]) + ppp_pkg::SUM_W'(r_prod[r][1])
                + ppp_pkg::SUM_W'(r_prod[r][2]);
            sh  = sum >>> ppp_pkg::FRAC_BITS;
            n_c[r] = ppp_pkg::CLIP_W'(sh) + ppp_pkg::CLIP_W'(r_off[r]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_proj;
            r_v2 <= r_v1;
        end
    end

    assign o_valid = r_v2;
    assign o_cx    = r_c[0];
    assign o_cy    = r_c[1];
    assign o_cw    = r_c[2];

endmodule

// File: src/ppp_div.sv
// ----------------------------------------------------------------------------
// ppp_div: pipelined restoring divider for one screen axis
// One quotient bit per stage, quotient capped, then signed and saturated.
// ----------------------------------------------------------------------------
module ppp_div (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic [ppp_pkg::NUM_W-1:0]      i_num,
    input  logic [ppp_pkg::DEN_W-1:0]      i_den,
    input  logic                           i_neg,
    output logic [ppp_pkg::W-1:0]          o_res
);

    localparam int Q = ppp_pkg::W;

    logic [ppp_pkg::REM_W-1:0] r_rem [Q+1];
    logic [Q-1:0]              r_low [Q+1];
    logic [Q-1:0]              r_q   [Q+1];
    logic [ppp_pkg::DEN_W-1:0] r_den [Q+1];
    logic                      r_neg [Q+1];
    logic                      r_ovf [Q+1];

    // A quotient of 2^32 or more shows when the high part reaches the divisor.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= ppp_pkg::REM_W'(i_num[ppp_pkg::NUM_W-1:Q]);
            r_low[0] <= i_num[Q-1:0];
            r_q[0]   <= '0;
            r_den[0] <= i_den;
            r_neg[0] <= i_neg;
            r_ovf[0] <= (ppp_pkg::NUM_W'(i_num[ppp_pkg::NUM_W-1:Q])
                         >= ppp_pkg::NUM_W'(i_den));
        end
    end

    for (genvar k = 1; k <= Q; k++) begin : g_step
        logic [ppp_pkg::REM_W-1:0] trial;
        logic                      take;
        assign trial = {r_rem[k-1][ppp_pkg::REM_W-2:0], r_low[k-1][Q-1]};
        assign take  = trial >= {1'b0, r_den[k-1]};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= take ? trial - {1'b0, r_den[k-1]} : trial;
                r_low[k] <= {r_low[k-1][Q-2:0], 1'b0};
                r_q[k]   <= {r_q[k-1][Q-2:0], take};
                r_den[k] <= r_den[k-1];
                r_neg[k] <= r_neg[k-1];
                r_ovf[k] <= r_ovf[k-1];
            end
        end
    end

    always_comb begin
        if (!r_neg[Q]) begin
            o_res = (r_ovf[Q] || r_q[Q][Q-1]) ? ppp_pkg::SAT_POS : r_q[Q];
        end else if (r_ovf[Q] || r_q[Q][Q-1]) begin
            o_res = ppp_pkg::SAT_NEG;
        end else begin
            o_res = Q'(0) - r_q[Q];
        end
    end

endmodule

// File: src/ppp_checker.sv
// ----------------------------------------------------------------------------
// ppp_checker: port-level checks for the projection block
// Watches the top-level ports and reports violations.
// ----------------------------------------------------------------------------
module ppp_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             o_s_axis_tready,
    input logic                             o_m_axis_tvalid,
    input logic                             i_m_axis_tready,
    input logic [ppp_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata,
    input logic                             o_m_axis_tuser
);

    // Nothing comes out in the cycle after reset.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid) else $error("result valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid
        && $stable(o_m_axis_tdata)) else $error("stalled result changed");

    // A hidden point carries all-zero data.
    a_hidden_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser |-> o_m_axis_tdata == '0)
        else $error("hidden result not zero");

    a_visible_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |->
        ($signed(o_m_axis_tdata[95:64]) > 0 &&
         $signed(o_m_axis_tdata[95:64]) >= ppp_pkg::THRESH))
        else $error("visible result below depth threshold");

    // With the output register empty the input side is open.
    a_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready) else $error("input blocked");

endmodule

bind perspective_point_projection ppp_checker u_ppp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);
